FILE: design/waypoint_steering_controller_top_defines.svh
// Assertion macros for the waypoint steering controller checker.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef WAYPOINT_STEERING_CONTROLLER_TOP_DEFINES_SVH
`define WAYPOINT_STEERING_CONTROLLER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/wsc_pkg.sv
// Shared constants, codes and the arctangent table of the steering controller.
// Used by the CORDIC unit, the top level and the port checker.
package wsc_pkg;

    localparam int WSC_COORD_BITS   = 24;
    localparam int WSC_CORDIC_STEPS = 16;

    // Angles are held in units of 2^-16 degree.
    localparam int ZW          = 28;
    localparam int ATAN_IB     = 5;
    localparam int CFG_W       = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int SPEED_W     = 10;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 3;
    localparam int IN_TUSER_W  = 2;

    localparam logic signed [ZW-1:0] DEG_30  = ZW'(30 * 65536);
    localparam logic signed [ZW-1:0] DEG_45  = ZW'(45 * 65536);
    localparam logic signed [ZW-1:0] DEG_180 = ZW'(180 * 65536);
    localparam logic signed [ZW-1:0] DEG_360 = ZW'(360 * 65536);

    localparam logic [1:0] ACT_STOP  = 2'd0;
    localparam logic [1:0] ACT_TURN  = 2'd1;
    localparam logic [1:0] ACT_DRIVE = 2'd2;
    localparam logic [1:0] ACT_HOLD  = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] CFG_DIST_TOL    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ANG_ENTER   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ANG_RELEASE = 2'd2;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [ATAN_IB-1:0] idx);
        logic signed [ZW-1:0] val;
        case (idx)
            5'd0:    val = ZW'(2949120);
            5'd1:    val = ZW'(1740967);
            5'd2:    val = ZW'(919879);
            5'd3:    val = ZW'(466945);
            5'd4:    val = ZW'(234379);
            5'd5:    val = ZW'(117304);
            5'd6:    val = ZW'(58666);
            5'd7:    val = ZW'(29335);
            5'd8:    val = ZW'(14668);
            5'd9:    val = ZW'(7334);
            5'd10:   val = ZW'(3667);
            5'd11:   val = ZW'(1833);
            5'd12:   val = ZW'(917);
            5'd13:   val = ZW'(458);
            5'd14:   val = ZW'(229);
            5'd15:   val = ZW'(115);
            5'd16:   val = ZW'(57);
            5'd17:   val = ZW'(29);
            5'd18:   val = ZW'(14);
            5'd19:   val = ZW'(7);
            5'd20:   val = ZW'(4);
            5'd21:   val = ZW'(2);
            5'd22:   val = ZW'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

FILE: design/wsc_cordic.sv
// Iterative CORDIC vectoring unit: one rotation step per cycle.
// Depends on wsc_pkg for the angle width and the arctangent table.
module wsc_cordic import wsc_pkg::*; #(
    parameter int XW    = WSC_COORD_BITS + 12,
    parameter int STEPS = WSC_CORDIC_STEPS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    output logic                 o_done,
    output logic signed [XW-1:0] o_x,
    output logic signed [ZW-1:0] o_z
);

    localparam int CW = $clog2(STEPS);

    logic signed [XW-1:0] r_x, r_y, n_xs, n_ys;
    logic signed [ZW-1:0] r_z, n_ang;
    logic [CW-1:0]        r_step;
    logic                 r_busy, r_done;

    always_comb begin
        n_xs  = r_x >>> r_step;
        n_ys  = r_y >>> r_step;
        n_ang = atan_q16(ATAN_IB'(r_step));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_start && (r_step == CW'(STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                if (i_x < 0) begin
                    r_x <= -i_x;
                    r_y <= -i_y;
                    r_z <= (i_y >= 0) ? DEG_180 : -DEG_180;
                end else begin
                    r_x <= i_x;
                    r_y <= i_y;
                    r_z <= '0;
                end
            end else if (r_busy) begin
                if (r_y > 0) begin
                    r_x <= r_x + n_ys;
                    r_y <= r_y - n_xs;
                    r_z <= r_z + n_ang;
                end else begin
                    r_x <= r_x - n_ys;
                    r_y <= r_y + n_xs;
                    r_z <= r_z - n_ang;
                end
                r_step <= r_step + 1'b1;
                if (r_step == CW'(STEPS - 1))
                    r_busy <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_z    = r_z;

endmodule

FILE: design/waypoint_steering_controller_top.sv
// Waypoint steering controller: distance and bearing by a shared CORDIC unit.
// A result is registered after the CORDIC steps, the distance scaling and the error wrap (the
// CORDIC unit is skipped for a zero vector, all of it without a target): one CORDIC step per cycle.
// Only one item is in work: the next item is taken once the result is registered.
// Synchronous active-low reset clears the sequencer, the output valid, the turn
// flag and the registers (tolerance 40, enter 20 degrees, release 5 degrees).
module waypoint_steering_controller_top import wsc_pkg::*; #(
    parameter int COORD_BITS   = WSC_COORD_BITS,
    parameter int CORDIC_STEPS = WSC_CORDIC_STEPS,
    localparam int IN_W        = 4 * COORD_BITS + 17,
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // target_x, target_y, pos_x, pos_y, heading, zero fill
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // target_valid, more_waypoints
    input  logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // left_speed, right_speed, zero fill
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // action, pop_waypoint
    output logic [OUT_TUSER_W-1:0] o_m_axis_tuser
);

    localparam int XW = COORD_BITS + 12;
    localparam logic [20:0] RECIP_25  = 21'd1342178;
    localparam logic [15:0] GAIN_INV  = 16'd39797;
    localparam logic [13:0] FWD_LIMIT = 14'd12800;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_CORD  = 4'd2;
    localparam logic [3:0] S_DIST1 = 4'd3;
    localparam logic [3:0] S_DIST2 = 4'd4;
    localparam logic [3:0] S_ERR   = 4'd5;
    localparam logic [3:0] S_WRAP  = 4'd6;
    localparam logic [3:0] S_DEC   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    function automatic logic signed [ZW-1:0] clamp(input logic signed [ZW-1:0] v,
                                                   input logic signed [ZW-1:0] lim);
        logic signed [ZW-1:0] r;
        if (v > lim)       r = lim;
        else if (v < -lim) r = -lim;
        else               r = v;
        return r;
    endfunction

    function automatic logic [SPEED_W-1:0] trunc_q16(input logic signed [ZW-1:0] v);
        logic signed [ZW-1:0] mag;
        logic [SPEED_W-1:0]   m;
        mag = (v < 0) ? -v : v;
        m   = SPEED_W'(mag >>> 16);
        return (v < 0) ? -m : m;
    endfunction

    logic [3:0]            r_state;
    logic [CFG_W-1:0]      r_tol;
    logic [7:0]            r_ang_enter, r_ang_release;
    logic                  r_flag;

    logic signed [XW-1:0]  r_dx, r_dy;
    logic [16:0]           r_habs;
    logic                  r_hsign;
    logic [19:0]           r_v;
    logic                  r_has, r_more, r_zero, r_eneg;
    logic signed [ZW-1:0]  r_hq, r_err;
    logic [31:0]           r_plo;
    logic [XW-1:0]         r_dist;

    logic [1:0]            r_act;
    logic [SPEED_W-1:0]    r_left, r_right;
    logic                  r_pop;

    logic                  r_ovalid;
    logic [OUT_TDATA_W-1:0] r_otdata;
    logic [OUT_TUSER_W-1:0] r_otuser;

    logic signed [COORD_BITS-1:0] n_tx, n_ty, n_px, n_py;
    logic signed [16:0]    n_hd;
    logic signed [COORD_BITS:0] n_ddx, n_ddy;
    logic [16:0]           n_habs;
    logic [40:0]           n_prod;
    logic [26:0]           n_hmag;
    logic signed [ZW-1:0]  n_hpos;

    logic                  c_start, c_done;
    logic signed [XW-1:0]  c_x;
    logic signed [ZW-1:0]  c_z;

    logic signed [ZW-1:0]  n_ae, n_ec, n_rc, n_fwd2, n_rot5;
    logic                  n_flag;
    logic [13:0]           n_dcl;

    always_comb begin
        n_tx   = i_s_axis_tdata[COORD_BITS-1:0];
        n_ty   = i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
        n_px   = i_s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
        n_py   = i_s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
        n_hd   = i_s_axis_tdata[4*COORD_BITS+16:4*COORD_BITS];
        n_ddx  = (COORD_BITS+1)'(n_tx) - (COORD_BITS+1)'(n_px);
        n_ddy  = (COORD_BITS+1)'(n_ty) - (COORD_BITS+1)'(n_py);
        n_habs = n_hd[16] ? 17'(-n_hd) : 17'(n_hd);

        // heading * 16384 / 25 is |heading| * 655 + |heading| * 9 / 25.
        n_prod = 41'(r_v) * 41'(RECIP_25);
        n_hmag = 27'(r_habs) * 27'd655 + 27'(n_prod[40:25]);
        n_hpos = ZW'($signed({1'b0, n_hmag}));

        c_start = (r_state == S_PREP) && r_has && !((r_dx == 0) && (r_dy == 0));

        n_ae   = (r_err < 0) ? -r_err : r_err;
        if ($unsigned(n_ae) > ZW'({r_ang_enter, 16'h0}))
            n_flag = 1'b1;
        else if ($unsigned(n_ae) < ZW'({r_ang_release, 16'h0}))
            n_flag = 1'b0;
        else
            n_flag = r_flag;
        n_ec   = clamp(r_err, DEG_30);
        n_rc   = clamp(r_err, DEG_45);
        n_dcl  = (r_dist > XW'(FWD_LIMIT)) ? FWD_LIMIT : r_dist[13:0];
        n_fwd2 = ZW'($signed({1'b0, n_dcl, 9'h0}));
        n_rot5 = (n_rc <<< 2) + n_rc;
    end

    wsc_cordic #(
        .XW    (XW),
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_x     (r_dx),
        .i_y     (r_dy),
        .o_done  (c_done),
        .o_x     (c_x),
        .o_z     (c_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol         <= CFG_W'(40);
            r_ang_enter   <= 8'd20;
            r_ang_release <= 8'd5;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DIST_TOL:    r_tol         <= i_cfg_wdata;
                CFG_ANG_ENTER:   r_ang_enter   <= i_cfg_wdata[7:0];
                CFG_ANG_RELEASE: r_ang_release <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_flag   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_axis_tready && (r_state != S_OUT))
                r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_dx    <= XW'(n_ddx) <<< 8;
                        r_dy    <= XW'(n_ddy) <<< 8;
                        r_habs  <= n_habs;
                        r_hsign <= n_hd[16];
                        r_v     <= 20'(n_habs) * 20'd9;
                        r_has   <= i_s_axis_tuser[0];
                        r_more  <= i_s_axis_tuser[1];
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_hq <= r_hsign ? -n_hpos : n_hpos;
                    if (!r_has) begin
                        r_act   <= ACT_STOP;
                        r_left  <= '0;
                        r_right <= '0;
                        r_pop   <= 1'b0;
                        r_state <= S_OUT;
                    end else if ((r_dx == 0) && (r_dy == 0)) begin
                        r_zero  <= 1'b1;
                        r_dist  <= '0;
                        r_state <= S_ERR;
                    end else begin
                        r_zero  <= 1'b0;
                        r_state <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (c_done)
                        r_state <= S_DIST1;
                end
                S_DIST1: begin
                    r_plo   <= 32'(c_x[15:0]) * 32'(GAIN_INV);
                    r_state <= S_DIST2;
                end
                S_DIST2: begin
                    r_dist  <= XW'(c_x[XW-1:16]) * XW'(GAIN_INV) + XW'(r_plo[31:16]);
                    r_state <= S_ERR;
                end
                S_ERR: begin
                    r_err   <= r_zero ? r_hq : (r_hq - c_z);
                    r_eneg  <= r_zero ? (r_hq < 0) : (r_hq < c_z);
                    r_state <= S_WRAP;
                end
                S_WRAP: begin
                    if (!r_eneg) begin
                        if (r_err >= DEG_180) r_err <= r_err - DEG_360;
                        else                  r_state <= S_DEC;
                    end else begin
                        if (r_err <= -DEG_180) r_err <= r_err + DEG_360;
                        else                   r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_flag <= n_flag;
                    if (n_flag) begin
                        r_act   <= ACT_TURN;
                        r_left  <= trunc_q16(-(n_ec <<< 1));
                        r_right <= trunc_q16(n_ec <<< 1);
                        r_pop   <= 1'b0;
                    end else if (r_dist >= XW'({r_tol, 8'h0})) begin
                        r_act   <= ACT_DRIVE;
                        r_left  <= trunc_q16(n_fwd2 - n_rot5);
                        r_right <= trunc_q16(n_fwd2 + n_rot5);
                        r_pop   <= 1'b0;
                    end else begin
                        r_act   <= ACT_HOLD;
                        r_left  <= '0;
                        r_right <= '0;
                        r_pop   <= r_more;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_otdata <= {{(OUT_TDATA_W - 2*SPEED_W){1'b0}}, r_right, r_left};
                        r_otuser <= {r_pop, r_act};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_otdata;
    assign o_m_axis_tuser  = r_otuser;

endmodule

FILE: design/wsc_checker.sv
// Port-level checker for the steering controller, bound to the top level.
// Depends on wsc_pkg and the assertion macros header.
`include "waypoint_steering_controller_top_defines.svh"

module wsc_checker import wsc_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] o_m_axis_tuser
);

    `WSC_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "Stalled result item changed")
    `WSC_ASSERT_NEXT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "Block took a second item while working")
    `WSC_ASSERT_SAME(a_stop_zero, o_m_axis_tvalid && (o_m_axis_tuser[1:0] == ACT_STOP), (o_m_axis_tdata[19:0] == 20'd0) && !o_m_axis_tuser[2], "Stop item carries nonzero fields")
    `WSC_ASSERT_SAME(a_pop_hold, o_m_axis_tvalid && o_m_axis_tuser[2], o_m_axis_tuser[1:0] == ACT_HOLD, "Waypoint pop outside a reached item")
    `WSC_ASSERT_SAME(a_turn_mirror, o_m_axis_tvalid && (o_m_axis_tuser[1:0] == ACT_TURN), (o_m_axis_tdata[9:0] + o_m_axis_tdata[19:10]) == 10'd0, "Turn item wheels not opposite")

endmodule

bind waypoint_steering_controller_top wsc_checker u_wsc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

FILE: tb/tb_waypoint_steering_controller_top.sv
// Testbench for the waypoint steering controller: directed and random control ticks are
// streamed in, each result is predicted by a bit-exact model of the steering law and checked.
// Depends on wsc_pkg and on waypoint_steering_controller_top.
import wsc_pkg::*;

localparam longint DEG_ONE_Q = 65536;
localparam longint HALF_TURN = 180 * DEG_ONE_Q;
localparam longint FULL_TURN = 360 * DEG_ONE_Q;
localparam longint GAIN_INV  = 39797;

typedef struct packed {
    logic               target_valid;
    logic               more_wp;
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [16:0] heading;
} tick_t;

typedef struct packed {
    logic [1:0]        action;
    logic signed [9:0] left_speed;
    logic signed [9:0] right_speed;
    logic              pop_waypoint;
} steer_t;

class steering_board;
    steer_t      steer_q[$];
    logic [15:0] dist_tol;
    logic [7:0]  angle_enter;
    logic [7:0]  angle_release;
    logic        turning;
    int          mismatches;
    int          checked;
    int          pops;
    int          act_count[4];

    function new();
        dist_tol = 16'd40;
        angle_enter = 8'd20;
        angle_release = 8'd5;
        turning = 1'b0;
        mismatches = 0;
        checked = 0;
        pops = 0;
        foreach (act_count[i]) act_count[i] = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
        case (idx)
            CFG_DIST_TOL:    dist_tol = val;
            CFG_ANG_ENTER:   angle_enter = val[7:0];
            CFG_ANG_RELEASE: angle_release = val[7:0];
            default: ;
        endcase
    endfunction

    // Bearing and range of a vector in 1/256 tick, angles in 2^-16 degree.
    function void measure(input longint vx, input longint vy,
                          output longint bearing, output longint reach);
        longint atan_tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                 58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
        longint x, y, z, xs, ys;
        x = vx;
        y = vy;
        z = 0;
        reach = 0;
        if (x != 0 || y != 0) begin
            if (x < 0) begin
                z = (y >= 0) ? HALF_TURN : -HALF_TURN;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < WSC_CORDIC_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x += ys;
                    y -= xs;
                    z += atan_tab[i];
                end else begin
                    x -= ys;
                    y += xs;
                    z -= atan_tab[i];
                end
            end
            reach = (x * GAIN_INV) >>> 16;
        end
        bearing = z;
    endfunction

    function longint clamp_deg(longint v, longint lim);
        return (v > lim) ? lim : ((v < -lim) ? -lim : v);
    endfunction

    function steer_t steer_for(tick_t t);
        steer_t r;
        longint bearing, reach, err, ae, e, fwd, rot, n, left, right;
        r = '0;
        r.action = ACT_STOP;
        left = 0;
        right = 0;
        if (!t.target_valid) return r;
        measure((longint'($signed(t.target_x)) - longint'($signed(t.pos_x))) * 256,
                (longint'($signed(t.target_y)) - longint'($signed(t.pos_y))) * 256,
                bearing, reach);
        err = longint'($signed(t.heading)) * 16384 / 25 - bearing;
        n = (err >= 0) ? (err + HALF_TURN) / FULL_TURN : -((-err + HALF_TURN) / FULL_TURN);
        err -= n * FULL_TURN;
        ae = (err < 0) ? -err : err;
        if (ae > longint'(angle_enter) * DEG_ONE_Q) turning = 1'b1;
        else if (ae < longint'(angle_release) * DEG_ONE_Q) turning = 1'b0;
        if (turning) begin
            e = clamp_deg(err, 30 * DEG_ONE_Q);
            r.action = ACT_TURN;
            left = (-2 * e) / DEG_ONE_Q;
            right = (2 * e) / DEG_ONE_Q;
        end else if (reach >= longint'(dist_tol) * 256) begin
            fwd = ((reach > 50 * 256) ? 50 * 256 : reach) * 256;
            rot = clamp_deg(err, 45 * DEG_ONE_Q);
            r.action = ACT_DRIVE;
            left = (2 * fwd - 5 * rot) / DEG_ONE_Q;
            right = (2 * fwd + 5 * rot) / DEG_ONE_Q;
        end else begin
            r.action = ACT_HOLD;
            r.pop_waypoint = t.more_wp;
        end
        r.left_speed = left[9:0];
        r.right_speed = right[9:0];
        return r;
    endfunction

    function void note_tick(tick_t t);
        steer_t r;
        r = steer_for(t);
        steer_q.insert(steer_q.size(), r);
        act_count[r.action]++;
        if (r.pop_waypoint) pops++;
    endfunction

    function void check_result(steer_t got);
        steer_t want;
        checked++;
        if (steer_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Result %0d arrived with no tick waiting", checked);
            return;
        end
        want = steer_q[0];
        steer_q.delete(0);
        if (got.action !== want.action || got.left_speed !== want.left_speed ||
            got.right_speed !== want.right_speed || got.pop_waypoint !== want.pop_waypoint) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Result %0d differs: expected action %0d left %0d right %0d pop %0d, %s %0d %0d %0d %0d",
                         checked, want.action, want.left_speed, want.right_speed,
                         want.pop_waypoint, "got", got.action, got.left_speed,
                         got.right_speed, got.pop_waypoint);
        end
    endfunction

    function int pending();
        return steer_q.size();
    endfunction
endclass

module tb_waypoint_steering_controller_top;
    localparam int TICK_TDATA_W = ((4 * WSC_COORD_BITS + 17 + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_PER_PHASE = 238;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_ADDR_W-1:0]   i_cfg_addr;
    logic [CFG_W-1:0]        i_cfg_wdata;
    logic                    i_s_axis_tvalid;
    logic                    o_s_axis_tready;
    logic [TICK_TDATA_W-1:0] i_s_axis_tdata;
    logic [IN_TUSER_W-1:0]   i_s_axis_tuser;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready;
    logic [OUT_TDATA_W-1:0]  o_m_axis_tdata;
    logic [OUT_TUSER_W-1:0]  o_m_axis_tuser;

    steering_board sb;
    int burst_left;
    int ready_left;
    int idle_cycles;
    int phases;

    waypoint_steering_controller_top dut (.*);

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_left = $urandom_range(1, 24);
            i_m_axis_tready <= ($urandom_range(0, 2) != 0);
        end else begin
            ready_left--;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result('{action: o_m_axis_tuser[1:0],
                                  left_speed: o_m_axis_tdata[9:0],
                                  right_speed: o_m_axis_tdata[19:10],
                                  pop_waypoint: o_m_axis_tuser[2]});
            if ((o_m_axis_tvalid && i_m_axis_tready) || (i_s_axis_tvalid && o_s_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic tick_t point_tick(logic ht, logic more, int tx, int ty, int px, int py,
                                         int hd);
        tick_t t;
        t.target_valid = ht;
        t.more_wp = more;
        t.target_x = 24'(tx);
        t.target_y = 24'(ty);
        t.pos_x = 24'(px);
        t.pos_y = 24'(py);
        t.heading = 17'(hd);
        return t;
    endfunction

    // Mostly short hops with the heading aimed near the bearing, so that the turn flag
    // releases and the drive and reach branches are exercised; a tenth is pure noise.
    function automatic tick_t random_tick();
        tick_t t;
        int scale, dx, dy, off, pick;
        longint bearing, reach, h;
        t.target_valid = ($urandom_range(0, 99) >= 8);
        t.more_wp = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) begin
            t.target_x = 24'($urandom);
            t.target_y = 24'($urandom);
            t.pos_x = 24'($urandom);
            t.pos_y = 24'($urandom);
            t.heading = 17'(int'($urandom_range(0, 72000)) - 36000);
            return t;
        end
        case ($urandom_range(0, 3))
            0: scale = 4;
            1: scale = 64;
            2: scale = 1024;
            default: scale = 140000;
        endcase
        dx = int'($urandom_range(0, 2 * scale)) - scale;
        dy = int'($urandom_range(0, 2 * scale)) - scale;
        pick = $urandom_range(0, 15);
        if (pick == 0) dx = 0;
        if (pick == 1) dy = 0;
        t.pos_x = 24'(int'($urandom_range(0, 16000000)) - 8000000);
        t.pos_y = 24'(int'($urandom_range(0, 16000000)) - 8000000);
        t.target_x = 24'(t.pos_x + dx);
        t.target_y = 24'(t.pos_y + dy);
        sb.measure(longint'(dx) * 256, longint'(dy) * 256, bearing, reach);
        case ($urandom_range(0, 3))
            0: off = 200;
            1: off = 1500;
            2: off = 4000;
            default: off = 18000;
        endcase
        h = bearing * 25 / 16384 + (int'($urandom_range(0, 2 * off)) - off);
        if (h > 36000) h -= 36000;
        else if (h < -36000) h += 36000;
        if ($urandom_range(0, 3) == 0) begin
            if (h <= 0) h += 36000;
            else h -= 36000;
        end
        t.heading = h[16:0];
        return t;
    endfunction

    task automatic send_tick(input tick_t t);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {7'd0, t.heading, t.pos_y, t.pos_x, t.target_y, t.target_x};
        i_s_axis_tuser <= {t.more_wp, t.target_valid};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_tick(t);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic run_phase(input logic [15:0] tol, input logic [7:0] enter,
                             input logic [7:0] rel, input int count);
        settle();
        write_reg(CFG_DIST_TOL, tol);
        write_reg(CFG_ANG_ENTER, {8'd0, enter});
        write_reg(CFG_ANG_RELEASE, {8'd0, rel});
        phases++;
        repeat (count) send_tick(random_tick());
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        i_m_axis_tready = 1'b0;
        sb = new();
        burst_left = 0;
        ready_left = 0;
        idle_cycles = 0;
        phases = 1;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero vectors give a bearing of zero, so the heading alone sets the error.
        send_tick(point_tick(0, 1, 8388607, -8388608, -8388608, 8388607, 36000));
        send_tick(point_tick(1, 1, 0, 0, 0, 0, 0));
        send_tick(point_tick(1, 0, 1234, -5678, 1234, -5678, 0));
        send_tick(point_tick(1, 1, 77, 77, 77, 77, 18000));
        send_tick(point_tick(1, 1, -9, 5, -9, 5, -18000));
        send_tick(point_tick(0, 0, 100, 100, 0, 0, -2500));
        send_tick(point_tick(1, 1, 3, 3, 3, 3, 1000));
        send_tick(point_tick(1, 1, 3, 3, 3, 3, 36000));
        send_tick(point_tick(1, 1, 3, 3, 3, 3, 2000));
        send_tick(point_tick(1, 1, 3, 3, 3, 3, 2001));
        send_tick(point_tick(1, 0, 3, 3, 3, 3, 500));
        send_tick(point_tick(1, 1, 3, 3, 3, 3, -499));
        send_tick(point_tick(1, 1, 3, 3, 3, 3, -36000));
        send_tick(point_tick(1, 0, 1000, 0, 0, 0, 0));
        send_tick(point_tick(1, 1, 0, 20, 0, 0, 9000));
        send_tick(point_tick(1, 1, 0, 5000, 0, 0, 9500));
        send_tick(point_tick(1, 0, -8388608, 0, 8388607, 0, 18000));
        send_tick(point_tick(1, 0, -8388608, -8388608, 8388607, 8388607, -13500));
        send_tick(point_tick(1, 1, 8388607, -8388608, -8388608, 8388607, -4500));
        send_tick(point_tick(1, 1, 8388607, -8388608, -8388608, 8388607, 18000));
        send_tick(point_tick(1, 1, -8388608, 8388607, 8388607, -8388608, 13500));
        send_tick(point_tick(1, 1, 40, 0, 0, 0, 0));
        send_tick(point_tick(1, 1, 41, 0, 0, 0, 0));

        settle();
        write_reg(CFG_SPARE, 16'hFFFF);
        run_phase(16'd40, 8'd20, 8'd5, RANDOM_PER_PHASE);
        run_phase(16'd0, 8'd0, 8'd0, RANDOM_PER_PHASE);
        run_phase(16'd65535, 8'd180, 8'd180, RANDOM_PER_PHASE);
        run_phase(16'd500, 8'd255, 8'd0, RANDOM_PER_PHASE);
        run_phase(16'd1000, 8'd45, 8'd10, RANDOM_PER_PHASE);
        run_phase(16'd2, 8'd10, 8'd30, RANDOM_PER_PHASE);
        settle();

        $display("Streamed %0d ticks under %0d register settings: %0d stop, %0d turn, %0d drive, %0d hold.",
                 sb.act_count[ACT_STOP] + sb.act_count[ACT_TURN] + sb.act_count[ACT_DRIVE]
                 + sb.act_count[ACT_HOLD], phases, sb.act_count[ACT_STOP],
                 sb.act_count[ACT_TURN], sb.act_count[ACT_DRIVE], sb.act_count[ACT_HOLD]);
        $display("Waypoint pops requested: %0d; results checked: %0d; mismatches: %0d.",
                 sb.pops, sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

FILE: waypoint_steering_controller_top.f
+incdir+design
design/wsc_pkg.sv
design/wsc_cordic.sv
design/waypoint_steering_controller_top.sv
design/wsc_checker.sv
tb/tb_waypoint_steering_controller_top.sv
